[rtl/column_closest_pixel_stego_embed_macros.svh]
// assertion macros shared by the checker of the column stego embedder
`ifndef COLUMN_CLOSEST_PIXEL_STEGO_EMBED_MACROS_SVH
`define COLUMN_CLOSEST_PIXEL_STEGO_EMBED_MACROS_SVH

// property that holds at every clock edge out of reset
`define CCPSE_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// property whose consequent must hold in the cycle after the antecedent
`define CCPSE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ccpse_pkg.sv]
// shared types, constants and helper functions of the column stego embedder
package ccpse_pkg;

   localparam int NUM_CH   = 3;
   localparam int CH_W     = 8;
   localparam int SEL_W    = 2;
   localparam int CHAR_W   = 7;
   localparam int POS_W    = 4;
   localparam int ROW_IN_W = 10;
   localparam int DEF_ROWS = 1024;

   // action codes carried in req_tuser
   localparam int          ACT_W      = 2;
   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_ENCODE = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;

   // register indexes on the csr port
   localparam int          CSR_ADDR_W   = 4;
   localparam int          CSR_DATA_W   = 32;
   localparam int          REG_LSB      = 2;
   localparam int          REG_IDX_W    = 2;
   localparam logic [1:0] REG_ENCODE_CH = 2'd0;
   localparam logic [1:0] REG_MARK_CH   = 2'd1;
   localparam logic [1:0] REG_RANK_CH   = 2'd2;
   localparam logic [1:0] RST_ENCODE_CH = 2'd2;
   localparam logic [1:0] RST_MARK_CH   = 2'd1;
   localparam logic [1:0] RST_RANK_CH   = 2'd0;
   localparam logic [1:0] CH_LAST       = 2'd2;

   // stream packing
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 40;
   localparam int ROW_LSB     = 0;
   localparam int CH0_LSB     = ROW_LSB + ROW_IN_W;
   localparam int CHAR_LSB    = CH0_LSB + NUM_CH * CH_W;
   localparam int POS_LSB     = CHAR_LSB + CHAR_W;
   localparam int RSP_PAD_W   = RSP_TDATA_W - ROW_IN_W - NUM_CH * CH_W;

   // decimal mark arithmetic
   localparam int             DEC_W     = 4;
   localparam logic [15:0]    RECIP_10  = 16'd205;
   localparam int             RECIP_SH  = 11;
   localparam logic [4:0]     DEC_BASE  = 5'd10;
   localparam logic [DEC_W-1:0] MARK_TAG = 4'd1;
   localparam logic [CH_W-1:0] CH_MAX   = 8'd255;
   localparam logic [CH_W-1:0] CH_ONE   = 8'd1;

   typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_type;

   typedef struct packed {
      logic [SEL_W-1:0] enc;
      logic [SEL_W-1:0] mark;
      logic [SEL_W-1:0] rank;
   } cfg_type;

   // token walking down the cell chain
   typedef struct packed {
      logic              valid;
      logic              is_read;
      logic              live;
      logic              hit;
      logic [CHAR_W-1:0] character;
      logic [CH_W-1:0]   gap;
      pixel_type         px;
   } token_type;

   // broadcast write into one cell
   typedef struct packed {
      logic              en;
      pixel_type         px;
      logic [NUM_CH-1:0] ones;
   } wr_type;

   function automatic logic [SEL_W-1:0] chan_sel(input logic [SEL_W-1:0] c);
      return (c > CH_LAST) ? CH_LAST : c;
   endfunction

   // remainder by ten through a reciprocal multiply, exact for 8-bit values
   function automatic logic [DEC_W-1:0] mod10(input logic [CH_W-1:0] v);
      logic [15:0]   prod;
      logic [4:0]    quo;
      logic [CH_W-1:0] rem;
      prod = 16'(v) * RECIP_10;
      quo  = prod[RECIP_SH +: 5];
      rem  = v - CH_W'(quo) * CH_W'(DEC_BASE);
      return rem[DEC_W-1:0];
   endfunction

   function automatic logic [CH_W-1:0] chan_pick(input pixel_type p,
                                                 input logic [SEL_W-1:0] c);
      logic [CH_W-1:0] v;
      case (c)
         2'd0: v = p[0];
         2'd1: v = p[1];
         default: v = p[2];
      endcase
      return v;
   endfunction

   function automatic pixel_type chan_put(input pixel_type p, input logic [SEL_W-1:0] c,
                                          input logic [CH_W-1:0] v);
      pixel_type q;
      q = p;
      case (c)
         2'd0: q[0] = v;
         2'd1: q[1] = v;
         default: q[2] = v;
      endcase
      return q;
   endfunction

   function automatic logic chan_bit(input logic [NUM_CH-1:0] f,
                                     input logic [SEL_W-1:0] c);
      logic b;
      case (c)
         2'd0: b = f[0];
         2'd1: b = f[1];
         default: b = f[2];
      endcase
      return b;
   endfunction

endpackage

[rtl/ccpse_cell.sv]
// one cell of the column chain: holds one pixel and steps the search token
module ccpse_cell import ccpse_pkg::*; #(
   parameter int ROW_W    = 10,
   parameter int CELL_ROW = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [SEL_W-1:0] enc_ch,
   input  logic [SEL_W-1:0] mark_ch,
   input  wr_type           wr,
   input  logic [ROW_W-1:0] wr_row,
   input  token_type        up_tok,
   input  logic [ROW_W-1:0] up_row,
   output token_type        dn_tok,
   output logic [ROW_W-1:0] dn_row
);

   localparam logic [ROW_W-1:0] MY_ROW = ROW_W'(CELL_ROW);
   // rows past the load address range never hold a pixel
   localparam bit LOADABLE = CELL_ROW < (1 << ROW_IN_W);

   pixel_type         px_ff;
   logic [NUM_CH-1:0] ones_ff;
   token_type         tok_ff, tok_in;
   logic [ROW_W-1:0]  row_ff, row_in;

   logic [CH_W-1:0] pv, chx, gap;
   logic            elig;

   always_comb begin
      pv   = chan_pick(px_ff, enc_ch);
      chx  = CH_W'(up_tok.character);
      gap  = (pv >= chx) ? (pv - chx) : (chx - pv);
      elig = LOADABLE && !chan_bit(ones_ff, mark_ch);

      tok_in = up_tok;
      row_in = up_row;
      if (up_tok.is_read) begin
         if (up_tok.live && (up_row == MY_ROW)) begin
            tok_in.hit = 1'b1;
            tok_in.px  = px_ff;
         end
      end else if (elig && (!up_tok.hit || (gap < up_tok.gap))) begin
         // strict compare keeps the earliest row on a tie
         tok_in.hit = 1'b1;
         tok_in.gap = gap;
         tok_in.px  = px_ff;
         row_in     = MY_ROW;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && (wr_row == MY_ROW)) begin
         px_ff <= wr.px;
      end
   end

   // an unloaded row looks used in every channel, so encode skips it
   always_ff @(posedge clock) begin
      if (reset) begin
         ones_ff <= '1;
      end else if (wr.en && (wr_row == MY_ROW)) begin
         ones_ff <= wr.ones;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
   end

   assign dn_tok = tok_ff;
   assign dn_row = row_ff;

endmodule

[rtl/ccpse_ctrl.sv]
// sequencer: launches tokens, applies pixel updates and holds the result register
module ccpse_ctrl import ccpse_pkg::*; #(
   parameter int ROWS  = DEF_ROWS,
   parameter int ROW_W = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [ACT_W-1:0]       req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tuser,
   output token_type              head_tok,
   output logic [ROW_W-1:0]       head_row,
   input  token_type              tail_tok,
   input  logic [ROW_W-1:0]       tail_row,
   output wr_type                 wr,
   output logic [ROW_W-1:0]       wr_row
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_UPDATE = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ROW_IN_W-1:0] rsp_row_ff, rsp_row_in;
   pixel_type           rsp_px_ff, rsp_px_in;
   logic                rsp_found_ff, rsp_found_in;

   logic [CHAR_W-1:0]   char_ff, char_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [ROW_IN_W-1:0] rrow_ff, rrow_in;
   pixel_type           wr_px_ff, wr_px_in;
   logic [ROW_W-1:0]    wr_row_ff, wr_row_in;
   logic                do_wr_ff, do_wr_in;
   logic                do_rsp_ff, do_rsp_in;
   logic [ROW_IN_W-1:0] out_row_ff, out_row_in;
   logic                found_ff, found_in;

   logic [ACT_W-1:0]    act;
   logic [ROW_IN_W-1:0] rq_row;
   pixel_type           rq_px;
   logic [CHAR_W-1:0]   rq_char;
   logic [POS_W-1:0]    rq_pos;
   logic                accept, in_range, go, wr_en;
   pixel_type           round_px, upd_px;
   logic [CH_W-1:0]     mval, rval;

   assign act     = req_tuser;
   assign rq_row  = req_tdata[ROW_LSB +: ROW_IN_W];
   assign rq_px   = req_tdata[CH0_LSB +: NUM_CH * CH_W];
   assign rq_char = req_tdata[CHAR_LSB +: CHAR_W];
   assign rq_pos  = req_tdata[POS_LSB +: POS_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign in_range   = ROWS > int'(rq_row);
   assign go         = !do_rsp_ff || !rsp_valid_ff || rsp_tready;

   // token launched into the first cell
   always_comb begin
      head_tok.valid     = accept && (act inside {ACT_ENCODE, ACT_READ});
      head_tok.is_read   = (act == ACT_READ);
      head_tok.live      = in_range;
      head_tok.hit       = 1'b0;
      head_tok.character = rq_char;
      head_tok.gap       = '0;
      head_tok.px        = '0;
      head_row           = (act == ACT_READ) ? ROW_W'(rq_row) : '0;
   end

   // load rounds the mark channel down to a multiple of ten
   always_comb begin
      mval     = chan_pick(rq_px, cfg.mark);
      round_px = chan_put(rq_px, cfg.mark, mval - CH_W'(mod10(mval)));
   end

   // encode updates: character, then mark, then rank, each on the last result
   always_comb begin
      upd_px = chan_put(wr_px_ff, cfg.enc, CH_W'(char_ff));
      rval   = chan_pick(upd_px, cfg.mark);
      if (rval != CH_MAX) begin
         rval = rval + CH_ONE;
      end
      upd_px = chan_put(upd_px, cfg.mark, rval);
      rval   = chan_pick(upd_px, cfg.rank);
      rval   = rval - CH_W'(mod10(rval)) + CH_W'(pos_ff);
      upd_px = chan_put(upd_px, cfg.rank, rval);
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_px_in    = rsp_px_ff;
      rsp_found_in = rsp_found_ff;
      char_in      = char_ff;
      pos_in       = pos_ff;
      rrow_in      = rrow_ff;
      wr_px_in     = wr_px_ff;
      wr_row_in    = wr_row_ff;
      do_wr_in     = do_wr_ff;
      do_rsp_in    = do_rsp_ff;
      out_row_in   = out_row_ff;
      found_in     = found_ff;
      wr_en        = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               char_in = rq_char;
               pos_in  = rq_pos;
               rrow_in = rq_row;
               if ((act == ACT_LOAD) && in_range) begin
                  wr_px_in  = round_px;
                  wr_row_in = ROW_W'(rq_row);
                  do_wr_in  = 1'b1;
                  do_rsp_in = 1'b0;
                  state_in  = ST_EMIT;
               end else if (act inside {ACT_ENCODE, ACT_READ}) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (tail_tok.valid) begin
               wr_px_in  = tail_tok.px;
               wr_row_in = tail_row;
               found_in  = tail_tok.hit;
               do_rsp_in = 1'b1;
               do_wr_in  = 1'b0;
               if (tail_tok.is_read) begin
                  out_row_in = rrow_ff;
                  state_in   = ST_EMIT;
               end else if (tail_tok.hit) begin
                  out_row_in = ROW_IN_W'(tail_row);
                  state_in   = ST_UPDATE;
               end else begin
                  out_row_in = '0;
                  state_in   = ST_EMIT;
               end
            end
         end
         ST_UPDATE: begin
            wr_px_in = upd_px;
            do_wr_in = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (go) begin
               wr_en = do_wr_ff;
               if (do_rsp_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_row_in   = out_row_ff;
                  rsp_px_in    = wr_px_ff;
                  rsp_found_in = found_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         do_wr_ff     <= 1'b0;
         do_rsp_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         do_wr_ff     <= do_wr_in;
         do_rsp_ff    <= do_rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_row_ff   <= rsp_row_in;
      rsp_px_ff    <= rsp_px_in;
      rsp_found_ff <= rsp_found_in;
      char_ff      <= char_in;
      pos_ff       <= pos_in;
      rrow_ff      <= rrow_in;
      wr_px_ff     <= wr_px_in;
      wr_row_ff    <= wr_row_in;
      out_row_ff   <= out_row_in;
      found_ff     <= found_in;
   end

   // per-channel used flags are worked out once, as the pixel is written
   always_comb begin
      wr.en = wr_en;
      wr.px = wr_px_ff;
      for (int c = 0; c < NUM_CH; c++) begin
         wr.ones[c] = (mod10(wr_px_ff[c]) == MARK_TAG);
      end
   end
   assign wr_row = wr_row_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_px_ff, rsp_row_ff};
   assign rsp_tuser  = rsp_found_ff;

endmodule

[rtl/column_closest_pixel_stego_embed.sv]
// top level of the column stego embedder: csr registers, sequencer and cell chain
//
// the column lives in a chain of ROWS cells, one pixel per cell; a load transfer
// writes straight into its cell; an encode or read transfer sends a token down
// the chain, one cell per cycle, and each cell folds its own pixel into the token
// (closest eligible pixel for encode, matching row for read); an encode has an
// extra update step that applies the character, mark and rank updates before the
// pixel is written back; one item is worked at a time, while a finished result
// waits in the output register and the next request transfer is already taken;
// that next encode's write back and any next result then hold until the waiting
// result is taken, while a load writes without waiting; rows never loaded are
// skipped by encode and hold no defined pixel for a read; the user must write the
// channel selects through the csr port only while the block is idle; the block
// itself does not enforce this
module column_closest_pixel_stego_embed import ccpse_pkg::*; #(
   parameter int ROWS = DEF_ROWS
) (
   input  logic                   clock,
   input  logic                   reset,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // row[9:0], chan0_in[17:10], chan1_in[25:18], chan2_in[33:26],
   // character[40:34], batch_pos[44:41], zero pad[47:45]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // action[1:0]
   input  logic [ACT_W-1:0]       req_tuser,
   // result stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // out_row[9:0], chan0_out[17:10], chan1_out[25:18], chan2_out[33:26],
   // zero pad[39:34]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // found[0]
   output logic                   rsp_tuser,
   // csr port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   // channel select registers
   logic [SEL_W-1:0]     enc_ch_ff, enc_ch_in;
   logic [SEL_W-1:0]     mark_ch_ff, mark_ch_in;
   logic [SEL_W-1:0]     rank_ch_ff, rank_ch_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 csr_wr;
   cfg_type              cfg;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[REG_LSB +: REG_IDX_W];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      enc_ch_in  = enc_ch_ff;
      mark_ch_in = mark_ch_ff;
      rank_ch_in = rank_ch_ff;
      if (csr_wr) begin
         case (reg_idx)
            REG_ENCODE_CH: enc_ch_in  = csr_pwdata[SEL_W-1:0];
            REG_MARK_CH:   mark_ch_in = csr_pwdata[SEL_W-1:0];
            REG_RANK_CH:   rank_ch_in = csr_pwdata[SEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enc_ch_ff  <= RST_ENCODE_CH;
         mark_ch_ff <= RST_MARK_CH;
         rank_ch_ff <= RST_RANK_CH;
      end else begin
         enc_ch_ff  <= enc_ch_in;
         mark_ch_ff <= mark_ch_in;
         rank_ch_ff <= rank_ch_in;
      end
   end

   // read back the stored value as written
   always_comb begin
      case (reg_idx)
         REG_ENCODE_CH: csr_prdata = CSR_DATA_W'(enc_ch_ff);
         REG_MARK_CH:   csr_prdata = CSR_DATA_W'(mark_ch_ff);
         REG_RANK_CH:   csr_prdata = CSR_DATA_W'(rank_ch_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // a select of three acts as channel two
   always_comb begin
      cfg.enc  = chan_sel(enc_ch_ff);
      cfg.mark = chan_sel(mark_ch_ff);
      cfg.rank = chan_sel(rank_ch_ff);
   end

   // token chain, entry 0 fed by the sequencer, last entry read back by it
   token_type        chain_tok [0:ROWS];
   logic [ROW_W-1:0] chain_row [0:ROWS];
   wr_type           wr;
   logic [ROW_W-1:0] wr_row;

   ccpse_ctrl #(
      .ROWS  (ROWS),
      .ROW_W (ROW_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .head_tok   (chain_tok[0]),
      .head_row   (chain_row[0]),
      .tail_tok   (chain_tok[ROWS]),
      .tail_row   (chain_row[ROWS]),
      .wr         (wr),
      .wr_row     (wr_row)
   );

   // one cell per row, each handing the token to the next every cycle
   for (genvar i = 0; i < ROWS; i++) begin : g_cell
      ccpse_cell #(
         .ROW_W    (ROW_W),
         .CELL_ROW (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .enc_ch  (cfg.enc),
         .mark_ch (cfg.mark),
         .wr      (wr),
         .wr_row  (wr_row),
         .up_tok  (chain_tok[i]),
         .up_row  (chain_row[i]),
         .dn_tok  (chain_tok[i+1]),
         .dn_row  (chain_row[i+1])
      );
   end

endmodule

[rtl/ccpse_check.sv]
// port-level checker of the column stego embedder and its bind
`include "column_closest_pixel_stego_embed_macros.svh"

module ccpse_check import ccpse_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TDATA_W-1:0] req_tdata,
   input logic [ACT_W-1:0]       req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tuser,
   input logic                   csr_psel,
   input logic                   csr_penable,
   input logic                   csr_pwrite,
   input logic [CSR_ADDR_W-1:0]  csr_paddr,
   input logic [CSR_DATA_W-1:0]  csr_pwdata,
   input logic [CSR_DATA_W-1:0]  csr_prdata,
   input logic                   csr_pready
);

   // a stalled result keeps its contents
   `CCPSE_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   // a miss carries an all-zero pixel
   `CCPSE_ASSERT_ALWAYS(a_miss_zero, !rsp_tvalid || rsp_tuser || (rsp_tdata[RSP_TDATA_W-RSP_PAD_W-1:ROW_IN_W] == '0), "miss with nonzero pixel")

   // a real item keeps the block busy for the next cycle
   `CCPSE_ASSERT_NEXT(a_one_item, req_tvalid && req_tready && (req_tuser == ACT_LOAD || req_tuser == ACT_ENCODE || req_tuser == ACT_READ), !req_tready, "second item taken while busy")

   // channel select registers read back only two bits
   `CCPSE_ASSERT_ALWAYS(a_csr_narrow, csr_prdata[CSR_DATA_W-1:SEL_W] == '0, "csr read data wider than a select")

endmodule

bind column_closest_pixel_stego_embed ccpse_check u_ccpse_check (.*);

[tb/column_closest_pixel_stego_embed_checker.sv]
// checker for the column stego embedder: mirrors the column and compares every result transfer
module column_closest_pixel_stego_embed_checker import ccpse_pkg::*; #(
   parameter int ROWS = DEF_ROWS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [ACT_W-1:0]       req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   rsp_tuser,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic                   csr_pready,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output int                     fail_count,
   output int                     pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DECADE     = 10;
   localparam int USED_DIGIT = 1;

   typedef struct packed {
      logic [ROW_IN_W-1:0] row;
      logic [CH_W-1:0]     chan0;
      logic [CH_W-1:0]     chan1;
      logic [CH_W-1:0]     chan2;
      logic                found;
   } pixel_result_type;

   logic [CH_W-1:0]  column_px [ROWS][NUM_CH];
   logic             column_loaded [ROWS];
   logic [SEL_W-1:0] enc_sel;
   logic [SEL_W-1:0] mark_sel;
   logic [SEL_W-1:0] rank_sel;
   pixel_result_type expected_pixels [$];
   int               mismatches = 0;

   function automatic logic [SEL_W-1:0] fold_sel(input logic [SEL_W-1:0] s);
      return (s > CH_LAST) ? CH_LAST : s;
   endfunction

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // mirror one accepted request and queue the result it should cause
   task automatic predict_column_op(input logic [ACT_W-1:0] act,
                                    input logic [REQ_TDATA_W-1:0] data);
      logic [ROW_IN_W-1:0] row;
      logic [CH_W-1:0]     chan [NUM_CH];
      logic [CHAR_W-1:0]   code;
      logic [POS_W-1:0]    pos;
      logic [SEL_W-1:0]    ec;
      logic [SEL_W-1:0]    mc;
      logic [SEL_W-1:0]    rc;
      int                  best;
      int                  gap;
      int                  pick;
      int                  v;
      bit                  hit;
      pixel_result_type    res;
      row  = data[ROW_LSB +: ROW_IN_W];
      for (int c = 0; c < NUM_CH; c++) chan[c] = data[CH0_LSB + c * CH_W +: CH_W];
      code = data[CHAR_LSB +: CHAR_W];
      pos  = data[POS_LSB +: POS_W];
      ec   = fold_sel(enc_sel);
      mc   = fold_sel(mark_sel);
      rc   = fold_sel(rank_sel);
      res  = '0;
      case (act)
         ACT_LOAD: begin
            if (row < ROWS) begin
               for (int c = 0; c < NUM_CH; c++) column_px[row][c] = chan[c];
               // mark channel drops to its decade on load
               v = int'(column_px[row][mc]);
               column_px[row][mc] = CH_W'(v - v % DECADE);
               column_loaded[row] = 1'b1;
            end
         end
         ACT_ENCODE: begin
            best = 1 << 30;
            pick = 0;
            hit  = 1'b0;
            // first unmarked pixel with the closest encode channel wins
            for (int r = 0; r < ROWS; r++) begin
               if (column_loaded[r] && (int'(column_px[r][mc]) % DECADE != USED_DIGIT)) begin
                  v   = int'(column_px[r][ec]);
                  gap = (v > int'(code)) ? v - int'(code) : int'(code) - v;
                  if (gap < best) begin
                     best = gap;
                     pick = r;
                     hit  = 1'b1;
                  end
               end
            end
            if (hit) begin
               // updates run in order, each one sees the previous
               column_px[pick][ec] = CH_W'(code);
               if (column_px[pick][mc] != CH_MAX)
                  column_px[pick][mc] = column_px[pick][mc] + CH_ONE;
               v = int'(column_px[pick][rc]);
               column_px[pick][rc] = CH_W'(v - v % DECADE + int'(pos));
               res.row   = ROW_IN_W'(pick);
               res.chan0 = column_px[pick][0];
               res.chan1 = column_px[pick][1];
               res.chan2 = column_px[pick][2];
               res.found = 1'b1;
            end
            expected_pixels = {expected_pixels, res};
         end
         ACT_READ: begin
            res.row = row;
            if (row < ROWS && column_loaded[row]) begin
               res.chan0 = column_px[row][0];
               res.chan1 = column_px[row][1];
               res.chan2 = column_px[row][2];
               res.found = 1'b1;
            end
            expected_pixels = {expected_pixels, res};
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         enc_sel  = RST_ENCODE_CH;
         mark_sel = RST_MARK_CH;
         rank_sel = RST_RANK_CH;
         foreach (column_loaded[r]) column_loaded[r] = 1'b0;
         expected_pixels.delete();
      end else begin
         // results first, so a fresh request never covers a stray result
         if (rsp_tvalid && rsp_tready) begin : result_check
            pixel_result_type want;
            pixel_result_type got;
            got.row   = rsp_tdata[ROW_LSB +: ROW_IN_W];
            got.chan0 = rsp_tdata[CH0_LSB +: CH_W];
            got.chan1 = rsp_tdata[CH0_LSB + CH_W +: CH_W];
            got.chan2 = rsp_tdata[CH0_LSB + 2 * CH_W +: CH_W];
            got.found = rsp_tuser;
            if (expected_pixels.size() == 0) begin
               mismatches++;
               $display("%0t: result transfer with none expected, expected none, actual %h",
                        $time, got);
            end else begin
               want = expected_pixels.pop_front();
               compare_field("out_row", 16'(want.row), 16'(got.row));
               compare_field("chan0_out", 16'(want.chan0), 16'(got.chan0));
               compare_field("chan1_out", 16'(want.chan1), 16'(got.chan1));
               compare_field("chan2_out", 16'(want.chan2), 16'(got.chan2));
               compare_field("found", 16'(want.found), 16'(got.found));
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[REG_LSB +: REG_IDX_W])
               REG_ENCODE_CH: enc_sel  = csr_pwdata[SEL_W-1:0];
               REG_MARK_CH:   mark_sel = csr_pwdata[SEL_W-1:0];
               REG_RANK_CH:   rank_sel = csr_pwdata[SEL_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_column_op(req_tuser, req_tdata);
      end
      fail_count      <= mismatches;
      pending_results <= expected_pixels.size();
   end

endmodule

[tb/column_closest_pixel_stego_embed_tb.sv]
// testbench top for the column stego embedder: stimulus, flow control and verdict
module column_closest_pixel_stego_embed_tb import ccpse_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         ROWS         = DEF_ROWS;
   localparam int         LIMIT_CYCLES = 3_000_000;
   // idle time after a drain, so a load's write has landed
   localparam int         SETTLE       = 16;
   // one full encode pass down the chain and some margin
   localparam int         TAIL         = ROWS + 16;
   localparam int         PHASES       = 6;
   localparam int         PHASE_ITEMS  = 78;
   // rows loaded up front, spread evenly over the column
   localparam int         FILL_ROWS    = 64;
   localparam int         FILL_STRIDE  = ROWS / FILL_ROWS;
   localparam logic [1:0] ACT_IGNORED  = 2'd3;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   // row[9:0], chan0_in[17:10], chan1_in[25:18], chan2_in[33:26],
   // character[40:34], batch_pos[44:41], zero pad[47:45]
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   // action[1:0]
   logic [ACT_W-1:0]       req_tuser   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   // out_row[9:0], chan0_out[17:10], chan1_out[25:18], chan2_out[33:26],
   // zero pad[39:34]
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // found[0]
   logic                   rsp_tuser;
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   int fail_count;
   int pending_results;
   int cycle_count   = 0;
   // random idling on both channels, switched off for the calm stretch
   bit traffic_gaps  = 1'b1;
   // rows that have been loaded, so reads only target written rows
   logic [ROW_IN_W-1:0] loaded_rows [$];

   // channel selects per random phase, covering both extremes and shared channels
   logic [SEL_W-1:0] phase_enc  [PHASES] = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd0, 2'd1};
   logic [SEL_W-1:0] phase_mark [PHASES] = '{2'd1, 2'd3, 2'd0, 2'd2, 2'd2, 2'd1};
   logic [SEL_W-1:0] phase_rank [PHASES] = '{2'd2, 2'd3, 2'd1, 2'd0, 2'd1, 2'd1};

   always #5 clock = ~clock;

   column_closest_pixel_stego_embed #(.ROWS(ROWS)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   column_closest_pixel_stego_embed_checker #(.ROWS(ROWS)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_pready      (csr_pready),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !traffic_gaps || ($urandom_range(99) >= 9);
      end
   end

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("column_closest_pixel_stego_embed regression: fail");
         $finish;
      end
   end

   function automatic logic [REQ_TDATA_W-1:0] pack_req(input logic [ROW_IN_W-1:0] row,
                                                       input logic [CH_W-1:0] c0, c1, c2,
                                                       input logic [CHAR_W-1:0] code,
                                                       input logic [POS_W-1:0] pos);
      logic [REQ_TDATA_W-1:0] d;
      d = '0;
      d[ROW_LSB +: ROW_IN_W]           = row;
      d[CH0_LSB +: CH_W]               = c0;
      d[CH0_LSB + CH_W +: CH_W]        = c1;
      d[CH0_LSB + 2 * CH_W +: CH_W]    = c2;
      d[CHAR_LSB +: CHAR_W]            = code;
      d[POS_LSB +: POS_W]              = pos;
      return d;
   endfunction

   // channel value leaning toward the ends of the range
   function automatic logic [CH_W-1:0] rand_chan();
      int pick;
      pick = $urandom_range(7);
      if (pick == 0) return '0;
      if (pick == 1) return CH_MAX;
      return CH_W'($urandom());
   endfunction

   // one request transfer; a gap lowers tvalid first, else tvalid stays high
   task automatic push_req(input logic [ACT_W-1:0] act, input logic [REQ_TDATA_W-1:0] data);
      if (traffic_gaps) begin
         while ($urandom_range(99) < 9) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // hold the sender until every expected transfer is back, then let loads settle
   task automatic drain(input int settle);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // setup then access phase, upper data bits are don't-care noise
   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [SEL_W-1:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx) << REG_LSB;
      csr_pwdata  <= {(CSR_DATA_W - SEL_W)'($urandom()), val};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int                  issued;
      int                  roll;
      logic [ACT_W-1:0]    act;
      logic [ROW_IN_W-1:0] row;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // load a spread of rows and the last row; channel 0 carries a used digit everywhere
      for (int r = 0; r < FILL_ROWS; r++) begin
         row = ROW_IN_W'(r * FILL_STRIDE);
         loaded_rows = {loaded_rows, row};
         push_req(ACT_LOAD, pack_req(row, CH_W'(10 * (r % 26) + 1), rand_chan(),
                                     rand_chan(), CHAR_W'($urandom()), POS_W'($urandom())));
      end
      loaded_rows = {loaded_rows, 10'd1023};
      push_req(ACT_LOAD, pack_req(10'd1023, CH_W'(1), rand_chan(), rand_chan(),
                                  CHAR_W'($urandom()), POS_W'($urandom())));

      // moving the mark to channel 0 leaves no eligible pixel
      drain(SETTLE);
      csr_write(REG_MARK_CH, 2'd0);
      push_req(ACT_ENCODE, pack_req('0, '0, '0, '0, 7'd65, 4'd3));
      push_req(ACT_READ, pack_req(10'd304, '0, '0, '0, '0, '0));
      drain(SETTLE);
      csr_write(REG_MARK_CH, RST_MARK_CH);

      // directed: extremes of rows, channels, characters and batch positions
      push_req(ACT_READ, pack_req(10'd0, '0, '0, '0, '0, '0));
      push_req(ACT_READ, pack_req(10'd1023, '1, '1, '1, '1, '1));
      push_req(ACT_ENCODE, pack_req('0, '0, '0, '0, 7'd0, 4'd0));
      push_req(ACT_ENCODE, pack_req('0, '0, '0, '0, 7'd127, 4'd9));
      // batch position past nine wraps through the byte
      push_req(ACT_ENCODE, pack_req('0, '0, '0, '0, 7'd64, 4'd15));
      push_req(ACT_LOAD, pack_req(10'd0, 8'd0, 8'd0, 8'd0, 7'd0, 4'd0));
      push_req(ACT_LOAD, pack_req(10'd1023, CH_MAX, CH_MAX, CH_MAX, 7'd127, 4'd15));
      push_req(ACT_READ, pack_req(10'd0, '0, '0, '0, '0, '0));
      push_req(ACT_READ, pack_req(10'd1023, '0, '0, '0, '0, '0));
      push_req(ACT_ENCODE, pack_req(10'd1023, '1, '1, '1, 7'd127, 4'd15));
      push_req(ACT_ENCODE, pack_req('0, '0, '0, '0, 7'd0, 4'd10));
      // reserved action code, dropped without a result
      push_req(ACT_IGNORED, pack_req('1, '1, '1, '1, '1, '1));
      push_req(ACT_LOAD, pack_req(10'd512, CH_MAX, CH_MAX, CH_MAX, '1, '1));
      push_req(ACT_READ, pack_req(10'd512, '0, '0, '0, '0, '0));
      push_req(ACT_ENCODE, pack_req(10'd512, 8'd1, 8'd1, 8'd1, 7'd100, 4'd5));
      push_req(ACT_READ, pack_req(10'd1023, '0, '0, '0, '0, '0));

      // random phases, each under its own channel selects
      for (int p = 0; p < PHASES; p++) begin
         drain(SETTLE);
         csr_write(REG_ENCODE_CH, phase_enc[p]);
         csr_write(REG_MARK_CH, phase_mark[p]);
         csr_write(REG_RANK_CH, phase_rank[p]);
         // third phase runs with no idling on either side
         traffic_gaps = (p != 2);
         issued = 0;
         while (issued < PHASE_ITEMS) begin
            roll = $urandom_range(99);
            if (roll < 5) begin
               act = ACT_IGNORED;
            end else if (roll < 45) begin
               act = ACT_LOAD;
            end else if (roll < 80) begin
               act = ACT_ENCODE;
            end else begin
               act = ACT_READ;
            end
            row = ROW_IN_W'($urandom());
            if (act == ACT_READ) row = loaded_rows[$urandom_range(loaded_rows.size() - 1)];
            if (act == ACT_LOAD) loaded_rows = {loaded_rows, row};
            push_req(act, pack_req(row, rand_chan(), rand_chan(),
                                   rand_chan(), CHAR_W'($urandom()), POS_W'($urandom())));
            if (act != ACT_IGNORED) issued++;
         end
      end
      traffic_gaps = 1'b1;

      // back to the reset selects for a last short burst
      drain(SETTLE);
      csr_write(REG_ENCODE_CH, RST_ENCODE_CH);
      csr_write(REG_MARK_CH, RST_MARK_CH);
      csr_write(REG_RANK_CH, RST_RANK_CH);
      for (int i = 0; i < 8; i++) begin
         push_req(ACT_ENCODE, pack_req('0, '0, '0, '0, CHAR_W'($urandom()), POS_W'($urandom())));
      end

      drain(TAIL);
      if (fail_count == 0 && pending_results == 0) begin
         $display("column_closest_pixel_stego_embed regression: pass");
      end else begin
         $display("column_closest_pixel_stego_embed regression: fail");
      end
      $finish;
   end

endmodule
